FILE: hdl/rov_pkg.sv
// Package: field widths, request codes, controller state and command/status types.
package rov_pkg;

   // Fixed payload field widths
   localparam int IDX_FW  = 6;
   localparam int POS_FW  = 7;
   localparam int CHR_W   = 8;
   localparam int OVL_W   = 7;

   // Default storage geometry
   localparam int NUM_READS_DEF = 64;
   localparam int READ_LEN_DEF  = 128;

   // Request type codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LEN_SRC,
      ST_LEN_DST,
      ST_FILL,
      ST_DRAIN,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_wr;
      logic latch_pair;
      logic len_rd_src;
      logic len_rd_dst;
      logic fill;
      logic scan_init;
      logic scan_shift;
      logic take_result;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic fill_done;
      logic scan_hit;
   } stat_type;

endpackage

FILE: hdl/rov_channels.sv
// Interfaces: request and response channels with valid/ready handshake.
interface rov_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [rov_pkg::IDX_FW-1:0]    read_index;
   logic [rov_pkg::POS_FW-1:0]    char_pos;
   logic [rov_pkg::CHR_W-1:0]     char_value;
   logic                          last_of_read;
   logic [rov_pkg::IDX_FW-1:0]    partner_index;

   modport source (
      output valid, req_type, read_index, char_pos, char_value, last_of_read,
             partner_index,
      input  ready
   );
   modport sink (
      input  valid, req_type, read_index, char_pos, char_value, last_of_read,
             partner_index,
      output ready
   );
endinterface

interface rov_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rov_pkg::OVL_W-1:0]     overlap_len;
   logic [rov_pkg::IDX_FW-1:0]    pair_source;
   logic [rov_pkg::IDX_FW-1:0]    pair_dest;

   modport source (
      output valid, overlap_len, pair_source, pair_dest,
      input  ready
   );
   modport sink (
      input  valid, overlap_len, pair_source, pair_dest,
      output ready
   );
endinterface

FILE: hdl/rov_ctrl.sv
// Controller: sequences clear pass, loads and the fill/scan steps of a query.
module rov_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_type,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  rov_pkg::stat_type stat,
   output rov_pkg::cmd_type  cmd
);

   rov_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rov_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rov_pkg::ST_CLEAR: begin
            if (stat.clear_done) state_in = rov_pkg::ST_IDLE;
         end
         rov_pkg::ST_IDLE: begin
            if (req_valid && req_type == rov_pkg::REQ_QUERY) state_in = rov_pkg::ST_LEN_SRC;
         end
         rov_pkg::ST_LEN_SRC: state_in = rov_pkg::ST_LEN_DST;
         rov_pkg::ST_LEN_DST: state_in = rov_pkg::ST_FILL;
         rov_pkg::ST_FILL: begin
            if (stat.fill_done) state_in = rov_pkg::ST_DRAIN;
         end
         rov_pkg::ST_DRAIN: state_in = rov_pkg::ST_SCAN;
         rov_pkg::ST_SCAN: begin
            if (stat.scan_hit) state_in = rov_pkg::ST_DONE;
         end
         rov_pkg::ST_DONE: begin
            if (rsp_ready) state_in = rov_pkg::ST_IDLE;
         end
         default: state_in = rov_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         rov_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         rov_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_wr    = (req_type == rov_pkg::REQ_LOAD);
               cmd.latch_pair = (req_type == rov_pkg::REQ_QUERY);
            end
         end
         rov_pkg::ST_LEN_SRC: cmd.len_rd_src = 1'b1;
         rov_pkg::ST_LEN_DST: cmd.len_rd_dst = 1'b1;
         rov_pkg::ST_FILL:    cmd.fill       = 1'b1;
         rov_pkg::ST_DRAIN:   cmd.scan_init  = 1'b1;
         rov_pkg::ST_SCAN: begin
            cmd.take_result = stat.scan_hit;
            cmd.scan_shift  = !stat.scan_hit;
         end
         rov_pkg::ST_DONE: rsp_valid = 1'b1;
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_ready_excl_valid: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a response is pending");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == rov_pkg::REQ_QUERY)
      |=> state_ff == rov_pkg::ST_LEN_SRC)
      else $error("accepted query did not start length fetch");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == rov_pkg::ST_CLEAR |-> !req_ready)
      else $error("request ready during length clear pass");
`endif

endmodule

FILE: hdl/rov_dpath.sv
// Datapath: read store, length store, shift registers and overlap compare.
module rov_dpath #(
   parameter int NUM_READS = rov_pkg::NUM_READS_DEF,
   parameter int READ_LEN  = rov_pkg::READ_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rov_pkg::cmd_type            cmd,
   output rov_pkg::stat_type           stat,
   input  logic [rov_pkg::IDX_FW-1:0]  read_index,
   input  logic [rov_pkg::POS_FW-1:0]  char_pos,
   input  logic [rov_pkg::CHR_W-1:0]   char_value,
   input  logic                        last_of_read,
   input  logic [rov_pkg::IDX_FW-1:0]  partner_index,
   output logic [rov_pkg::OVL_W-1:0]   overlap_len,
   output logic [rov_pkg::IDX_FW-1:0]  pair_source,
   output logic [rov_pkg::IDX_FW-1:0]  pair_dest
);

   localparam int POS_W = (READ_LEN > 1) ? $clog2(READ_LEN) : 1;
   localparam int IDX_W = (NUM_READS > 1) ? $clog2(NUM_READS) : 1;
   localparam int LEN_W = $clog2(READ_LEN + 1);
   localparam int AW    = IDX_W + POS_W;
   localparam int DEPTH = NUM_READS * (2 ** POS_W);
   localparam int CW    = rov_pkg::CHR_W;

   // Storage
   logic [CW-1:0]    store_mem [DEPTH];
   logic [LEN_W-1:0] len_mem   [NUM_READS];

   // Load decode
   logic            load_ok;
   logic [AW-1:0]   st_waddr;
   assign load_ok  = (32'(read_index) < NUM_READS) && (32'(char_pos) < READ_LEN);
   assign st_waddr = {IDX_W'(read_index), POS_W'(char_pos)};

   // Pair registers
   logic [rov_pkg::IDX_FW-1:0] src_ff, dst_ff;
   logic                       pair_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_pair) begin
         src_ff     <= read_index;
         dst_ff     <= partner_index;
         pair_ok_ff <= (32'(read_index) < NUM_READS) && (32'(partner_index) < NUM_READS)
                       && (read_index != partner_index);
      end
   end

   // Control counters and capture flags
   logic [IDX_W-1:0] clr_cnt_ff;
   logic [POS_W-1:0] fill_cnt_ff;
   logic             cap_ff, ls_cap_ff, ld_cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         fill_cnt_ff <= '0;
         cap_ff      <= 1'b0;
         ls_cap_ff   <= 1'b0;
         ld_cap_ff   <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.latch_pair) begin
            fill_cnt_ff <= '0;
         end else if (cmd.fill) begin
            fill_cnt_ff <= fill_cnt_ff + 1'b1;
         end
         cap_ff    <= cmd.fill;
         ls_cap_ff <= cmd.len_rd_src;
         ld_cap_ff <= cmd.len_rd_dst;
      end
   end

   assign stat.clear_done = (clr_cnt_ff == IDX_W'(NUM_READS - 1));
   assign stat.fill_done  = (fill_cnt_ff == POS_W'(READ_LEN - 1));

   // Character store: one write port, two registered read ports
   logic [AW-1:0] src_raddr, dst_raddr;
   logic [CW-1:0] src_rd_ff, dst_rd_ff;
   assign src_raddr = {IDX_W'(src_ff), fill_cnt_ff};
   assign dst_raddr = {IDX_W'(dst_ff), fill_cnt_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_wr && load_ok) store_mem[st_waddr] <= char_value;
      src_rd_ff <= store_mem[src_raddr];
      dst_rd_ff <= store_mem[dst_raddr];
   end

   // Length store: cleared after reset, written on last character, one read port
   logic             len_we;
   logic [IDX_W-1:0] len_waddr, len_raddr;
   logic [LEN_W-1:0] len_wdata, len_rd_ff;

   always_comb begin
      if (cmd.clear_step) begin
         len_we    = 1'b1;
         len_waddr = clr_cnt_ff;
         len_wdata = '0;
      end else begin
         len_we    = cmd.load_wr && load_ok && last_of_read;
         len_waddr = IDX_W'(read_index);
         len_wdata = LEN_W'(char_pos) + 1'b1;
      end
      len_raddr = cmd.len_rd_dst ? IDX_W'(dst_ff) : IDX_W'(src_ff);
   end

   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_waddr] <= len_wdata;
      len_rd_ff <= len_mem[len_raddr];
   end

   // Read lengths
   logic [LEN_W-1:0] ls_ff, ld_ff;
   always_ff @(posedge clock) begin
      if (ls_cap_ff) ls_ff <= len_rd_ff;
      if (ld_cap_ff) ld_ff <= len_rd_ff;
   end

   // Shift registers: filled from the top, source shifts down once per scan step
   logic [CW-1:0] src_sh_ff [READ_LEN];
   logic [CW-1:0] dst_sh_ff [READ_LEN];

   always_ff @(posedge clock) begin
      if (cap_ff) begin
         for (int i = 0; i < READ_LEN - 1; i++) begin
            src_sh_ff[i] <= src_sh_ff[i+1];
            dst_sh_ff[i] <= dst_sh_ff[i+1];
         end
         src_sh_ff[READ_LEN-1] <= src_rd_ff;
         dst_sh_ff[READ_LEN-1] <= dst_rd_ff;
      end else if (cmd.scan_shift) begin
         for (int i = 0; i < READ_LEN - 1; i++) begin
            src_sh_ff[i] <= src_sh_ff[i+1];
         end
         src_sh_ff[READ_LEN-1] <= '0;
      end
   end

   // Candidate overlap length, counts down from source length minus one
   logic [LEN_W-1:0] n_ff;
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         n_ff <= (ls_ff == '0) ? '0 : ls_ff - 1'b1;
      end else if (cmd.scan_shift) begin
         n_ff <= n_ff - 1'b1;
      end
   end

   // Parallel compare: source suffix (offset by one) against destination prefix
   logic [READ_LEN-2:0] eq;
   logic                shift_match;
   always_comb begin
      for (int i = 0; i < READ_LEN - 1; i++) begin
         eq[i] = (src_sh_ff[i+1] == dst_sh_ff[i]) || (LEN_W'(i) >= n_ff);
      end
   end
   assign shift_match = &eq;

   logic no_overlap;
   assign no_overlap    = !pair_ok_ff || (n_ff == '0);
   assign stat.scan_hit = no_overlap || (shift_match && (ld_ff >= n_ff));

   // Result register
   logic [rov_pkg::OVL_W-1:0]  res_len_ff;
   logic [rov_pkg::IDX_FW-1:0] res_src_ff, res_dst_ff;
   always_ff @(posedge clock) begin
      if (cmd.take_result) begin
         res_len_ff <= no_overlap ? '0 : rov_pkg::OVL_W'(n_ff);
         res_src_ff <= src_ff;
         res_dst_ff <= dst_ff;
      end
   end

   assign overlap_len = res_len_ff;
   assign pair_source = res_src_ff;
   assign pair_dest   = res_dst_ff;

`ifndef SYNTHESIS
   a_scan_counts_down: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_shift |=> n_ff == $past(n_ff) - 1'b1)
      else $error("candidate length did not step down");

   a_bad_pair_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_result && !pair_ok_ff) |=> res_len_ff == '0)
      else $error("nonzero overlap for an invalid read pair");

   a_no_shift_on_fill: assert property (@(posedge clock) disable iff (reset)
      !(cap_ff && cmd.scan_shift))
      else $error("scan shift collides with store capture");
`endif

endmodule

FILE: hdl/read_overlap_engine_core.sv
// Top level: suffix-prefix overlap engine over a store of sequence reads.
//
// req_ch carries one transaction per item. A load (req_type 0) writes one
// character of read read_index at char_pos; with last_of_read set, the read's
// length becomes char_pos + 1. Loads produce no response. A query (req_type 1)
// produces one rsp_ch transaction with the longest proper suffix of read
// read_index that matches a prefix of read partner_index. A query fills two
// read registers through the character store's two read ports (one character
// per port per cycle), then does one shifted compare of all positions per
// cycle. One item is in flight at a time. After reset the length store is
// cleared, one read per cycle; req_ch.ready stays low during that pass. The
// response is held in a register until rsp_ch.ready; while it waits no new
// request is accepted.
module read_overlap_engine_core #(
   parameter int NUM_READS = rov_pkg::NUM_READS_DEF,
   parameter int READ_LEN  = rov_pkg::READ_LEN_DEF
) (
   input logic       clock,
   input logic       reset,
   rov_req_if.sink   req_ch,
   rov_rsp_if.source rsp_ch
);

   rov_pkg::cmd_type  cmd;
   rov_pkg::stat_type stat;

   rov_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rov_dpath #(
      .NUM_READS (NUM_READS),
      .READ_LEN  (READ_LEN)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .read_index    (req_ch.read_index),
      .char_pos      (req_ch.char_pos),
      .char_value    (req_ch.char_value),
      .last_of_read  (req_ch.last_of_read),
      .partner_index (req_ch.partner_index),
      .overlap_len   (rsp_ch.overlap_len),
      .pair_source   (rsp_ch.pair_source),
      .pair_dest     (rsp_ch.pair_dest)
   );

endmodule

FILE: bench/read_overlap_engine_core_test.sv
// Self-checking bench for read_overlap_engine_core: read loads, overlap queries, scoreboard.
module read_overlap_engine_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_READS   = rov_pkg::NUM_READS_DEF;
   localparam int READ_LEN    = rov_pkg::READ_LEN_DEF;
   localparam int IDX_FW      = rov_pkg::IDX_FW;
   localparam int POS_FW      = rov_pkg::POS_FW;
   localparam int CHR_W       = rov_pkg::CHR_W;
   localparam int OVL_W       = rov_pkg::OVL_W;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 2 * READ_LEN + 40;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic              req_type;
      logic [IDX_FW-1:0] read_index;
      logic [POS_FW-1:0] char_pos;
      logic [CHR_W-1:0]  char_value;
      logic              last_of_read;
      logic [IDX_FW-1:0] partner_index;
   } overlap_req_type;

   typedef struct packed {
      logic [OVL_W-1:0]  overlap_len;
      logic [IDX_FW-1:0] pair_source;
      logic [IDX_FW-1:0] pair_dest;
   } overlap_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // driven side of both channels
   logic            drv_valid = 1'b0;
   overlap_req_type drv_item  = '0;
   logic            rcv_ready = 1'b0;

   rov_req_if req_if ();
   rov_rsp_if rsp_if ();

   assign req_if.valid         = drv_valid;
   assign req_if.req_type      = drv_item.req_type;
   assign req_if.read_index    = drv_item.read_index;
   assign req_if.char_pos      = drv_item.char_pos;
   assign req_if.char_value    = drv_item.char_value;
   assign req_if.last_of_read  = drv_item.last_of_read;
   assign req_if.partner_index = drv_item.partner_index;
   assign rsp_if.ready         = rcv_ready;

   read_overlap_engine_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   overlap_req_type pending_reqs[$];
   overlap_rsp_type expected_overlaps[$];

   int send_idle_pct    = 0;
   int rcv_idle_pct     = 0;
   int mismatches       = 0;
   int overlaps_checked = 0;
   int stall_cycles     = 0;
   int hold_left        = 0;
   bit hold_done        = 1'b0;

   // predictor state, updated on accepted transactions
   logic [CHR_W-1:0] char_mem [NUM_READS][READ_LEN];
   int               len_mem  [NUM_READS] = '{default: 0};

   // generator shadow, used only to keep queries away from unwritten characters
   logic [CHR_W-1:0] gen_chr [NUM_READS][READ_LEN];
   bit               gen_wr  [NUM_READS][READ_LEN] = '{default: '{default: 1'b0}};
   int               gen_len [NUM_READS] = '{default: 0};
   int               recent_reads[$];
   int               phase_items = 0;
   int               big_left    = 1;

   // longest proper suffix of src equal to a prefix of dst
   function automatic logic [OVL_W-1:0] predict_overlap(int src, int dst);
      int ls;
      int ld;
      bit hit;
      if (src >= NUM_READS || dst >= NUM_READS || src == dst) return '0;
      ls = (len_mem[src] > READ_LEN) ? READ_LEN : len_mem[src];
      ld = (len_mem[dst] > READ_LEN) ? READ_LEN : len_mem[dst];
      if (ls < 2) return '0;
      for (int n = ls - 1; n >= 1; n--) begin
         if (ld >= n) begin
            hit = 1'b1;
            for (int k = 0; k < n; k++) begin
               if (char_mem[src][ls - n + k] != char_mem[dst][k]) hit = 1'b0;
            end
            if (hit) return n[OVL_W-1:0];
         end
      end
      return '0;
   endfunction

   // apply one accepted transaction to the predictor
   task automatic apply_request(input overlap_req_type r);
      overlap_rsp_type e;
      if (r.req_type == rov_pkg::REQ_LOAD) begin
         if (r.read_index < NUM_READS && r.char_pos < READ_LEN) begin
            char_mem[r.read_index][r.char_pos] = r.char_value;
            if (r.last_of_read) len_mem[r.read_index] = r.char_pos + 1;
         end
      end else begin
         e.overlap_len = predict_overlap(r.read_index, r.partner_index);
         e.pair_source = r.read_index;
         e.pair_dest   = r.partner_index;
         expected_overlaps = {expected_overlaps, e};
      end
   endtask

   function automatic bit read_clean(int idx);
      for (int p = 0; p < gen_len[idx]; p++) begin
         if (!gen_wr[idx][p]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // a query never compares an unwritten character
   function automatic bit query_safe(int src, int dst);
      if (src == dst || gen_len[src] < 2) return 1'b1;
      return read_clean(src) && read_clean(dst);
   endfunction

   task automatic push_load(input int idx, input int pos, input int val, input bit last);
      overlap_req_type r;
      r.req_type      = rov_pkg::REQ_LOAD;
      r.read_index    = IDX_FW'(idx);
      r.char_pos      = POS_FW'(pos);
      r.char_value    = CHR_W'(val);
      r.last_of_read  = last;
      r.partner_index = IDX_FW'($urandom_range(0, NUM_READS - 1));
      pending_reqs = {pending_reqs, r};
      if (idx < NUM_READS && pos < READ_LEN) begin
         gen_chr[idx][pos] = CHR_W'(val);
         gen_wr[idx][pos]  = 1'b1;
         if (last) gen_len[idx] = pos + 1;
      end
      phase_items++;
   endtask

   task automatic push_query(input int src, input int dst);
      overlap_req_type r;
      r.req_type      = rov_pkg::REQ_QUERY;
      r.read_index    = IDX_FW'(src);
      r.char_pos      = POS_FW'($urandom_range(0, READ_LEN - 1));
      r.char_value    = CHR_W'($urandom_range(0, 255));
      r.last_of_read  = 1'($urandom_range(0, 1));
      r.partner_index = IDX_FW'(dst);
      pending_reqs = {pending_reqs, r};
      phase_items++;
   endtask

   // whole read; prefix optionally copied from a suffix of donor, fill >= 0 gives a uniform read
   task automatic load_read(input int idx, input int len, input int donor, input int fill);
      logic [CHR_W-1:0] content [READ_LEN];
      logic [CHR_W-1:0] acgt [4];
      int alpha;
      int dlen;
      int k;
      int pos;
      bit backward;
      acgt  = '{8'h41, 8'h43, 8'h47, 8'h54};
      alpha = $urandom_range(0, 3);
      content[0] = CHR_W'($urandom_range(0, 255));
      for (int p = 0; p < len; p++) begin
         if (fill >= 0) content[p] = CHR_W'(fill);
         else if (alpha == 0) content[p] = CHR_W'($urandom_range(0, 255));
         else if (alpha == 3) content[p] = content[0];
         else content[p] = acgt[$urandom_range(0, 3)];
      end
      if (donor >= 0 && donor != idx && gen_len[donor] >= 2 && read_clean(donor)) begin
         dlen = gen_len[donor];
         k = $urandom_range(1, (len < dlen - 1) ? len : dlen - 1);
         for (int j = 0; j < k; j++) content[j] = gen_chr[donor][dlen - k + j];
      end
      backward = ($urandom_range(0, 4) == 0);
      for (int p = 0; p < len; p++) begin
         pos = backward ? len - 1 - p : p;
         push_load(idx, pos, content[pos], pos == len - 1);
      end
   endtask

   task automatic random_phase(input int budget);
      int pick;
      int idx;
      int len;
      int donor;
      int src;
      int dst;
      int sel;
      while (phase_items < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            // well-formed read, often chained to a recent one
            idx = $urandom_range(0, NUM_READS - 1);
            sel = $urandom_range(0, 29);
            if (sel == 0 && big_left > 0) begin
               len = $urandom_range(100, READ_LEN);
               big_left--;
            end else if (sel < 3) begin
               len = 1;
            end else begin
               len = $urandom_range(2, 12);
            end
            donor = (recent_reads.size() > 0) ?
                    recent_reads[$urandom_range(0, recent_reads.size() - 1)] : -1;
            load_read(idx, len, donor, -1);
            recent_reads = {recent_reads, idx};
            if (recent_reads.size() > 8) void'(recent_reads.pop_front());
            if (donor >= 0 && query_safe(donor, idx)) push_query(donor, idx);
            if (donor >= 0 && query_safe(idx, donor)) push_query(idx, donor);
         end else if (pick < 85) begin
            // burst of queries over recent and arbitrary reads
            repeat ($urandom_range(1, 4)) begin
               src = 0;
               dst = 0;
               for (int t = 0; t < 10; t++) begin
                  if (recent_reads.size() > 0 && $urandom_range(0, 1)) begin
                     src = recent_reads[$urandom_range(0, recent_reads.size() - 1)];
                     dst = recent_reads[$urandom_range(0, recent_reads.size() - 1)];
                  end else begin
                     src = $urandom_range(0, NUM_READS - 1);
                     dst = $urandom_range(0, NUM_READS - 1);
                  end
                  if ($urandom_range(0, 9) == 0) dst = src;
                  if (query_safe(src, dst)) break;
                  dst = src;
               end
               push_query(src, dst);
            end
         end else begin
            // stray loads at arbitrary positions
            repeat ($urandom_range(1, 3)) begin
               push_load($urandom_range(0, NUM_READS - 1), $urandom_range(0, READ_LEN - 1),
                         $urandom_range(0, 255), $urandom_range(0, 3) == 0);
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || drv_valid || expected_overlaps.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_if.ready) apply_request(drv_item);
         if (!drv_valid || req_if.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drv_item  <= pending_reqs.pop_front();
               drv_valid <= 1'b1;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver back-pressure
   always @(posedge clock) begin
      overlap_rsp_type got;
      overlap_rsp_type want;
      if (reset) begin
         rcv_ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rcv_ready) begin
            got.overlap_len = rsp_if.overlap_len;
            got.pair_source = rsp_if.pair_source;
            got.pair_dest   = rsp_if.pair_dest;
            if (expected_overlaps.size() == 0) begin
               $display("%0t: unexpected transaction: len %0d src %0d dst %0d", $time,
                        got.overlap_len, got.pair_source, got.pair_dest);
               mismatches++;
            end else begin
               want = expected_overlaps.pop_front();
               if (got.overlap_len !== want.overlap_len) begin
                  $display("%0t: overlap_len expected %0d actual %0d (src %0d dst %0d)", $time,
                           want.overlap_len, got.overlap_len, want.pair_source, want.pair_dest);
                  mismatches++;
               end
               if (got.pair_source !== want.pair_source) begin
                  $display("%0t: pair_source expected %0d actual %0d", $time,
                           want.pair_source, got.pair_source);
                  mismatches++;
               end
               if (got.pair_dest !== want.pair_dest) begin
                  $display("%0t: pair_dest expected %0d actual %0d", $time,
                           want.pair_dest, got.pair_dest);
                  mismatches++;
               end
            end
            overlaps_checked++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rcv_ready <= 1'b0;
         end else if (!hold_done && overlaps_checked == 10) begin
            // one long hold-off so the request side backs up
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            rcv_ready <= 1'b0;
         end else begin
            rcv_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (!reset) begin
         if ((drv_valid && req_if.ready) || (rsp_if.valid && rcv_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // stimulus sequence
   initial begin
      send_idle_pct = 32;
      rcv_idle_pct  = 62;

      // unset reads and same read
      push_query(0, NUM_READS - 1);
      push_query(5, 5);
      // read 1 = 00 FF 00, read 2 = FF 00 7E
      push_load(1, 0, 8'h00, 1'b0);
      push_load(1, 1, 8'hFF, 1'b0);
      push_load(1, 2, 8'h00, 1'b1);
      push_load(2, 0, 8'hFF, 1'b0);
      push_load(2, 1, 8'h00, 1'b0);
      push_load(2, 2, 8'h7E, 1'b1);
      push_query(1, 2);
      push_query(2, 1);
      push_query(1, 1);
      // single-character read: too short as source, short destination
      push_load(3, 0, 8'h00, 1'b1);
      push_query(3, 1);
      push_query(1, 3);
      // top position without the last flag leaves the length unset
      push_load(NUM_READS - 1, READ_LEN - 1, 8'hFF, 1'b0);
      push_query(NUM_READS - 1, 1);
      // rewrite shortens read 2 to one character
      push_load(2, 0, 8'h00, 1'b1);
      push_query(1, 2);
      // top position with the last flag: read 0 becomes full length, mostly unwritten
      push_load(0, READ_LEN - 1, 8'h80, 1'b1);
      random_phase(100);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      phase_items   = 0;
      send_idle_pct = 62;
      rcv_idle_pct  = 32;
      random_phase(70);
      wait_drained();

      // two full-length uniform reads give the largest overlap
      phase_items   = 0;
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      load_read(NUM_READS - 2, READ_LEN, -1, 8'h5A);
      load_read(NUM_READS - 1, READ_LEN, -1, 8'h5A);
      push_query(NUM_READS - 2, NUM_READS - 1);
      push_query(NUM_READS - 1, NUM_READS - 2);
      recent_reads = {recent_reads, NUM_READS - 1};
      random_phase(phase_items + 20);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_overlaps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/rov_pkg.sv
hdl/rov_channels.sv
hdl/rov_ctrl.sv
hdl/rov_dpath.sv
hdl/read_overlap_engine_core.sv
bench/read_overlap_engine_core_test.sv
